FILE: rtl/core/lbf_pkg.sv
// ----------------------------------------------------------------------------
// lbf_pkg
// Shared types and constants for the line-aware byte fifo: request and status
// codes, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lbf_pkg;

  // default storage depth and fixed field widths
  localparam int DEPTH_DEF = 64;
  localparam int REQ_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int STS_W     = 2;
  localparam int LVL_W     = 7;
  localparam int CFG_W     = 7;

  // reset value of the capacity register
  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  // the byte that closes a line
  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_LINE = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [STS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NO_LINE = 2'd3
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_EXEC,
    CTL_APPEND
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;   // capture the incoming request
    logic step;    // produce one result beat and update the fifo
    logic append;  // this step pushes the appended newline
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;     // output register can take a beat this cycle
    logic step_last;    // the beat being produced closes the request
    logic append_next;  // a newline push follows this beat
  } ctl_sts_t;

endpackage

FILE: rtl/core/lbf_ctrl.sv
// ----------------------------------------------------------------------------
// lbf_ctrl
// Request sequencer: takes one request, then steps the datapath once per
// result beat until the closing beat has been loaded into the output register.
// ----------------------------------------------------------------------------
module lbf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lbf_pkg::ctl_sts_t sts,
  output lbf_pkg::ctl_cmd_t cmd
);

  lbf_pkg::ctl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lbf_pkg::CTL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lbf_pkg::CTL_IDLE: begin
        if (in_valid) begin
          state_nxt = lbf_pkg::CTL_EXEC;
        end
      end
      lbf_pkg::CTL_EXEC: begin
        if (sts.out_free) begin
          priority if (sts.step_last) begin
            state_nxt = lbf_pkg::CTL_IDLE;
          end else if (sts.append_next) begin
            state_nxt = lbf_pkg::CTL_APPEND;
          end else begin
            state_nxt = lbf_pkg::CTL_EXEC;
          end
        end
      end
      lbf_pkg::CTL_APPEND: begin
        if (sts.out_free) begin
          state_nxt = lbf_pkg::CTL_IDLE;
        end
      end
      default: state_nxt = lbf_pkg::CTL_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall   = 1'b1;
    cmd.latch  = 1'b0;
    cmd.step   = 1'b0;
    cmd.append = 1'b0;
    unique case (state_r)
      lbf_pkg::CTL_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      lbf_pkg::CTL_EXEC: begin
        cmd.step = sts.out_free;
      end
      lbf_pkg::CTL_APPEND: begin
        cmd.step   = sts.out_free;
        cmd.append = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/core/lbf_datapath.sv
// ----------------------------------------------------------------------------
// lbf_datapath
// Byte store with pointers, fill and newline counts, the capacity register,
// the request holding register and the result output register.
// ----------------------------------------------------------------------------
module lbf_datapath #(
  parameter int DEPTH = lbf_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request payload
  input  logic [lbf_pkg::REQ_W-1:0]   in_req_type,
  input  logic [lbf_pkg::BYTE_W-1:0]  in_data_in,
  input  logic                        in_end_of_string,
  // capacity register write
  input  logic                        cfg_write_en,
  input  logic [lbf_pkg::CFG_W-1:0]   cfg_capacity_in_use,
  // controller link
  input  lbf_pkg::ctl_cmd_t           cmd,
  output lbf_pkg::ctl_sts_t           sts,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lbf_pkg::STS_W-1:0]   out_status,
  output logic [lbf_pkg::BYTE_W-1:0]  out_data_out,
  output logic                        out_last,
  output logic [lbf_pkg::LVL_W-1:0]   out_fill_level,
  output logic [lbf_pkg::LVL_W-1:0]   out_lines_stored
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // byte store and registered read port
  logic [lbf_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [lbf_pkg::BYTE_W-1:0] rdata_r;

  // fifo control state
  logic [PTR_W-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [CNT_W-1:0]          nl_r, nl_nxt;
  logic [lbf_pkg::CFG_W-1:0] cap_r;

  // held request
  lbf_pkg::req_t              req_r;
  logic [lbf_pkg::BYTE_W-1:0] data_r;
  logic                       eos_r;

  // output register
  logic                        out_valid_r;
  lbf_pkg::status_t            out_status_r;
  logic [lbf_pkg::BYTE_W-1:0]  out_data_r;
  logic                        out_last_r;
  logic [CNT_W-1:0]            out_fill_r;
  logic [CNT_W-1:0]            out_lines_r;

  // step results
  logic                       rd_adv, wr_adv, cnt_inc, cnt_dec, nl_inc, nl_dec;
  lbf_pkg::status_t           res_status;
  logic [lbf_pkg::BYTE_W-1:0] res_data;
  logic                       res_last;
  logic [lbf_pkg::BYTE_W-1:0] push_byte;
  logic [CNT_W-1:0]           cap_eff;
  logic                       is_empty, is_full, head_nl, mem_we;

  // effective capacity: zero acts as one, anything above the depth as the depth
  always_comb begin
    priority if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_r > lbf_pkg::CFG_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(p) + CNT_W'(1);
    return (inc >= cap) ? '0 : PTR_W'(inc);
  endfunction

  assign is_empty  = (cnt_r == '0);
  assign is_full   = (cnt_r >= cap_eff);
  assign head_nl   = (rdata_r == lbf_pkg::NEWLINE);
  assign push_byte = cmd.append ? lbf_pkg::NEWLINE : data_r;

  // one result beat of the held request
  always_comb begin
    rd_adv     = 1'b0;
    wr_adv     = 1'b0;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    nl_inc     = 1'b0;
    nl_dec     = 1'b0;
    res_status = lbf_pkg::ST_OK;
    res_data   = '0;
    res_last   = 1'b1;
    unique case (req_r)
      lbf_pkg::REQ_PUSH: begin
        res_last = cmd.append || !(eos_r && (data_r != lbf_pkg::NEWLINE));
        if (is_full) begin
          res_status = lbf_pkg::ST_FULL;
        end else begin
          wr_adv  = 1'b1;
          cnt_inc = 1'b1;
          nl_inc  = (push_byte == lbf_pkg::NEWLINE);
        end
      end
      lbf_pkg::REQ_POP, lbf_pkg::REQ_PEEK: begin
        if (is_empty) begin
          res_status = lbf_pkg::ST_EMPTY;
        end else begin
          res_data = rdata_r;
          if (req_r == lbf_pkg::REQ_POP) begin
            rd_adv  = 1'b1;
            cnt_dec = 1'b1;
            nl_dec  = head_nl && (nl_r != '0);
          end
        end
      end
      lbf_pkg::REQ_LINE: begin
        priority if (is_empty) begin
          res_status = lbf_pkg::ST_EMPTY;
        end else if (nl_r == '0) begin
          res_status = lbf_pkg::ST_NO_LINE;
        end else begin
          res_data = rdata_r;
          rd_adv   = 1'b1;
          cnt_dec  = 1'b1;
          nl_dec   = head_nl;
          res_last = head_nl || (cnt_r == CNT_W'(1));
        end
      end
      default: res_status = lbf_pkg::ST_OK;
    endcase
  end

  assign mem_we = cmd.step && wr_adv;

  // next pointers and counts; a capacity write starts the fifo afresh
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    nl_nxt     = nl_r;
    if (cfg_write_en) begin
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      cnt_nxt    = '0;
      nl_nxt     = '0;
    end else if (cmd.step) begin
      if (rd_adv) rd_ptr_nxt = advance(rd_ptr_r, cap_eff);
      if (wr_adv) wr_ptr_nxt = advance(wr_ptr_r, cap_eff);
      if (cnt_inc) cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_dec) cnt_nxt = cnt_r - CNT_W'(1);
      if (nl_inc) nl_nxt = nl_r + CNT_W'(1);
      if (nl_dec) nl_nxt = nl_r - CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
      nl_r     <= '0;
      cap_r    <= lbf_pkg::CAP_RESET;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
      nl_r     <= nl_nxt;
      if (cfg_write_en) begin
        cap_r <= cfg_capacity_in_use;
      end
    end
  end

  // byte store; the read port follows the next head, with write-through
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= push_byte;
    end
    if (mem_we && (wr_ptr_r == rd_ptr_nxt)) begin
      rdata_r <= push_byte;
    end else begin
      rdata_r <= mem[rd_ptr_nxt];
    end
  end

  // request holding register
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r  <= lbf_pkg::req_t'(in_req_type);
      data_r <= in_data_in;
      eos_r  <= in_end_of_string;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_status_r <= res_status;
      out_data_r   <= res_data;
      out_last_r   <= res_last;
      out_fill_r   <= cnt_nxt;
      out_lines_r  <= nl_nxt;
    end
  end

  // status to the controller
  assign sts.out_free    = !out_valid_r || !out_stall;
  assign sts.step_last   = res_last;
  assign sts.append_next = (req_r == lbf_pkg::REQ_PUSH) && !cmd.append && !res_last;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_data_out     = out_data_r;
  assign out_last         = out_last_r;
  assign out_fill_level   = lbf_pkg::LVL_W'(out_fill_r);
  assign out_lines_stored = lbf_pkg::LVL_W'(out_lines_r);

endmodule

FILE: rtl/core/line_aware_byte_fifo_unit.sv
// ----------------------------------------------------------------------------
// line_aware_byte_fifo_unit
// Circular byte fifo with programmable capacity, single-byte push, pop and
// peek, end-of-string newline append and whole-line readout.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+--------------------------------
//   in_     | input     | in_valid/in_stall | req_type, data_in, end_of_string
//   out_    | output    | out_valid/stall   | status, data_out, last,
//           |           |                   | fill_level, lines_stored
//   cfg_    | input     | cfg_write_en      | capacity_in_use
//
// A request is taken while the sequencer is idle; it then steps once per result
// beat into the output register: one beat for pop, peek, an empty or no-line
// answer and a plain push, two for an end-of-string push of a byte other than a
// newline and n for a line of n bytes. The final beat may wait in the output
// register while the next request is taken. Output stall holds the sequencer;
// no beat is lost. Reset empties the fifo and sets the capacity to 64; a
// capacity write empties it as well.
//
module line_aware_byte_fifo_unit #(
  parameter int DEPTH = lbf_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lbf_pkg::REQ_W-1:0]   in_req_type,
  input  logic [lbf_pkg::BYTE_W-1:0]  in_data_in,
  input  logic                        in_end_of_string,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lbf_pkg::STS_W-1:0]   out_status,
  output logic [lbf_pkg::BYTE_W-1:0]  out_data_out,
  output logic                        out_last,
  output logic [lbf_pkg::LVL_W-1:0]   out_fill_level,
  output logic [lbf_pkg::LVL_W-1:0]   out_lines_stored,
  input  logic                        cfg_write_en,
  input  logic [lbf_pkg::CFG_W-1:0]   cfg_capacity_in_use
);

  lbf_pkg::ctl_cmd_t cmd;
  lbf_pkg::ctl_sts_t sts;

  // request sequencer
  lbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, counters and output register
  lbf_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_req_type         (in_req_type),
    .in_data_in          (in_data_in),
    .in_end_of_string    (in_end_of_string),
    .cfg_write_en        (cfg_write_en),
    .cfg_capacity_in_use (cfg_capacity_in_use),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_data_out        (out_data_out),
    .out_last            (out_last),
    .out_fill_level      (out_fill_level),
    .out_lines_stored    (out_lines_stored)
  );

  // fill level never exceeds the storage depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fill_level <= lbf_pkg::LVL_W'(DEPTH)))
    else $error("fill level beyond depth");

  // stored newlines are a subset of the stored bytes
  a_lines_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lines_stored <= out_fill_level))
    else $error("newline count above fill level");

  // one request at a time: an accepted request holds off the next
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in flight");

  // an empty or no-line answer always closes its request
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == lbf_pkg::ST_EMPTY || out_status == lbf_pkg::ST_NO_LINE))
      |-> out_last)
    else $error("error beat not marked last");

endmodule

FILE: verif/tb_line_aware_byte_fifo_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_aware_byte_fifo_unit
// Self-checking bench for the line-aware byte fifo. It runs a table of
// directed requests (empty and full cases, appended newlines, line readout,
// capacity extremes) and then random strings, line pops and loose requests.
// The random phases run at several capacities and idling patterns. A local
// mirror of the fifo predicts every result beat, which is checked field by
// field in order.
// ----------------------------------------------------------------------------
module tb_line_aware_byte_fifo_unit;
  import lbf_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 15;
  localparam int PHASES       = 4;

  // one expected result beat
  typedef struct packed {
    status_t             status;
    logic [BYTE_W-1:0]   data;
    logic                last;
    logic [LVL_W-1:0]    fill;
    logic [LVL_W-1:0]    lines;
  } beat_t;

  // directed table row: a request or a capacity write
  typedef enum logic {ROW_REQ, ROW_CAP} row_kind_t;
  typedef struct {
    row_kind_t          kind;
    req_t               req;
    logic [BYTE_W-1:0]  data;
    logic               eos;
    logic               typed;
    status_t            t_status;
    logic [BYTE_W-1:0]  t_data;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [REQ_W-1:0]    in_req_type;
  logic [BYTE_W-1:0]   in_data_in;
  logic                in_end_of_string;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STS_W-1:0]    out_status;
  logic [BYTE_W-1:0]   out_data_out;
  logic                out_last;
  logic [LVL_W-1:0]    out_fill_level;
  logic [LVL_W-1:0]    out_lines_stored;
  logic                cfg_write_en;
  logic [CFG_W-1:0]    cfg_capacity_in_use;

  // typed expectation riding along with a directed request
  logic                dir_typed;
  status_t             dir_status;
  logic [BYTE_W-1:0]   dir_data;

  // fifo mirror
  logic [BYTE_W-1:0]   mirror_mem [0:DEPTH_DEF-1];
  int unsigned         rd_slot;
  int unsigned         wr_slot;
  int unsigned         held;
  int unsigned         nl_held;
  logic [CFG_W-1:0]    cap_reg;

  beat_t               pending_beats [$];
  int                  mismatches;
  int                  requests_sent;
  int                  beats_checked;
  int                  gap_pct;
  int                  stall_pct;
  row_t                plan [26];

  line_aware_byte_fifo_unit #(.DEPTH(DEPTH_DEF)) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_data_in          (in_data_in),
    .in_end_of_string    (in_end_of_string),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_data_out        (out_data_out),
    .out_last            (out_last),
    .out_fill_level      (out_fill_level),
    .out_lines_stored    (out_lines_stored),
    .cfg_write_en        (cfg_write_en),
    .cfg_capacity_in_use (cfg_capacity_in_use)
  );

  always #10 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // ---------------------------------------------------------------- mirror
  function automatic int unsigned mirror_capacity();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH_DEF) return DEPTH_DEF;
    return 32'(cap_reg);
  endfunction

  function automatic int unsigned next_slot(int unsigned p);
    return (p + 1 >= mirror_capacity()) ? 0 : p + 1;
  endfunction

  function automatic void mirror_clear();
    rd_slot = 0;
    wr_slot = 0;
    held    = 0;
    nl_held = 0;
  endfunction

  function automatic status_t mirror_push(logic [BYTE_W-1:0] b);
    if (held >= mirror_capacity()) return ST_FULL;
    mirror_mem[wr_slot] = b;
    wr_slot = next_slot(wr_slot);
    held++;
    if (b == NEWLINE) nl_held++;
    return ST_OK;
  endfunction

  function automatic logic [BYTE_W-1:0] mirror_pop();
    logic [BYTE_W-1:0] b;
    b = mirror_mem[rd_slot];
    rd_slot = next_slot(rd_slot);
    held--;
    if (b == NEWLINE && nl_held > 0) nl_held--;
    return b;
  endfunction

  function automatic void add_beat(status_t st, logic [BYTE_W-1:0] d, logic lst);
    pending_beats.push_back('{st, d, lst, LVL_W'(held), LVL_W'(nl_held)});
  endfunction

  // works out every beat one request causes
  function automatic void mirror_request(req_t req, logic [BYTE_W-1:0] d, logic eos);
    logic              extra;
    status_t           st;
    logic [BYTE_W-1:0] b;
    case (req)
      REQ_PUSH: begin
        extra = eos && (d != NEWLINE);
        st = mirror_push(d);
        add_beat(st, 8'h00, !extra);
        if (extra) begin
          st = mirror_push(NEWLINE);
          add_beat(st, 8'h00, 1'b1);
        end
      end
      REQ_POP, REQ_PEEK: begin
        if (held == 0) begin
          add_beat(ST_EMPTY, 8'h00, 1'b1);
        end else if (req == REQ_POP) begin
          b = mirror_pop();
          add_beat(ST_OK, b, 1'b1);
        end else begin
          add_beat(ST_OK, mirror_mem[rd_slot], 1'b1);
        end
      end
      REQ_LINE: begin
        if (held == 0) begin
          add_beat(ST_EMPTY, 8'h00, 1'b1);
        end else if (nl_held == 0) begin
          add_beat(ST_NO_LINE, 8'h00, 1'b1);
        end else begin
          do begin
            b = mirror_pop();
            add_beat(ST_OK, b, b == NEWLINE);
          end while (b != NEWLINE && held > 0);
        end
      end
    endcase
  endfunction

  // accepted request: predict, then apply any typed expectation
  function automatic void record_request();
    int    first;
    beat_t b;
    first = pending_beats.size();
    mirror_request(req_t'(in_req_type), in_data_in, in_end_of_string);
    if (dir_typed) begin
      b = pending_beats[first];
      b.status = dir_status;
      b.data   = dir_data;
      pending_beats[first] = b;
    end
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_beat();
    beat_t want;
    if (pending_beats.size() == 0) begin
      $display("%0t: unexpected beat, status %0d data %02h", $time, out_status,
               out_data_out);
      mismatches++;
      return;
    end
    want = pending_beats.pop_front();
    beats_checked++;
    compare_field("status", 32'(want.status), 32'(out_status));
    compare_field("data_out", 32'(want.data), 32'(out_data_out));
    compare_field("last", 32'(want.last), 32'(out_last));
    compare_field("fill_level", 32'(want.fill), 32'(out_fill_level));
    compare_field("lines_stored", 32'(want.lines), 32'(out_lines_stored));
  endfunction

  // input acceptance first, then result beats
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) record_request();
    if (rst_n && out_valid && !out_stall) check_beat();
  end

  // ---------------------------------------------------------------- driving
  task automatic send_request(req_t req, logic [BYTE_W-1:0] d, logic eos,
                              logic typed, status_t ts, logic [BYTE_W-1:0] td);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_req_type      = req;
    in_data_in       = d;
    in_end_of_string = eos;
    dir_typed        = typed;
    dir_status       = ts;
    dir_data         = td;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid  = 1'b0;
    dir_typed = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  // capacity writes only once the fifo has gone quiet
  task automatic write_capacity(logic [CFG_W-1:0] v);
    drain_results();
    @(negedge clk);
    cfg_write_en        = 1'b1;
    cfg_capacity_in_use = v;
    @(negedge clk);
    cfg_write_en = 1'b0;
    cap_reg = v;
    mirror_clear();
  endtask

  function automatic logic [BYTE_W-1:0] text_byte();
    logic [BYTE_W-1:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == NEWLINE) ? 8'h0B : b;
  endfunction

  // a string of len bytes, the last one flagged as end of string
  task automatic send_string(int len);
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      b = text_byte();
      if (i == len - 1 && $urandom_range(0, 3) == 0) b = NEWLINE;
      send_request(REQ_PUSH, b, i == len - 1, 1'b0, ST_OK, 8'h00);
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  initial begin
    logic [CFG_W-1:0] phase_cap [PHASES];
    int               phase_gap [PHASES];
    int               phase_stall [PHASES];
    int               sent;
    int               len;
    int               top;
    logic [BYTE_W-1:0] d;
    logic             paused;

    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_req_type         = REQ_PUSH;
    in_data_in          = 8'h00;
    in_end_of_string    = 1'b0;
    cfg_write_en        = 1'b0;
    cfg_capacity_in_use = CAP_RESET;
    dir_typed           = 1'b0;
    dir_status          = ST_OK;
    dir_data            = 8'h00;
    mismatches          = 0;
    requests_sent       = 0;
    beats_checked       = 0;
    gap_pct             = 0;
    stall_pct           = 0;
    cap_reg             = CAP_RESET;
    paused              = 1'b0;
    mirror_clear();

    phase_cap   = '{7'd64, 7'd3, 7'd127, 7'd17};
    phase_gap   = '{0, 80, 0, 14};
    phase_stall = '{0, 0, 80, 14};

    plan = '{
      // empty fifo: every read reports empty
      '{ROW_REQ, REQ_POP,  8'h00, 1'b0, 1'b1, ST_EMPTY,   8'h00},
      '{ROW_REQ, REQ_PEEK, 8'h00, 1'b0, 1'b1, ST_EMPTY,   8'h00},
      '{ROW_REQ, REQ_LINE, 8'h00, 1'b0, 1'b1, ST_EMPTY,   8'h00},
      '{ROW_REQ, REQ_PUSH, 8'h00, 1'b0, 1'b1, ST_OK,      8'h00},
      // bytes stored but no newline yet
      '{ROW_REQ, REQ_LINE, 8'h00, 1'b0, 1'b1, ST_NO_LINE, 8'h00},
      // end of string appends a newline, unless the byte is one
      '{ROW_REQ, REQ_PUSH, 8'hFF, 1'b1, 1'b0, ST_OK,      8'h00},
      '{ROW_REQ, REQ_PUSH, 8'h0A, 1'b1, 1'b0, ST_OK,      8'h00},
      '{ROW_REQ, REQ_PEEK, 8'h00, 1'b0, 1'b1, ST_OK,      8'h00},
      '{ROW_REQ, REQ_PUSH, 8'h41, 1'b0, 1'b0, ST_OK,      8'h00},
      '{ROW_REQ, REQ_LINE, 8'h00, 1'b0, 1'b0, ST_OK,      8'h00},
      '{ROW_REQ, REQ_LINE, 8'h00, 1'b0, 1'b0, ST_OK,      8'h00},
      '{ROW_REQ, REQ_POP,  8'h00, 1'b0, 1'b1, ST_OK,      8'h41},
      '{ROW_REQ, REQ_POP,  8'h00, 1'b0, 1'b1, ST_EMPTY,   8'h00},
      // zero capacity behaves as one entry
      '{ROW_CAP, REQ_PUSH, 8'd0,  1'b0, 1'b0, ST_OK,      8'h00},
      '{ROW_REQ, REQ_PUSH, 8'h0A, 1'b0, 1'b1, ST_OK,      8'h00},
      '{ROW_REQ, REQ_PUSH, 8'h55, 1'b1, 1'b0, ST_OK,      8'h00},
      '{ROW_REQ, REQ_PUSH, 8'h0A, 1'b1, 1'b1, ST_FULL,    8'h00},
      '{ROW_REQ, REQ_LINE, 8'h00, 1'b0, 1'b0, ST_OK,      8'h00},
      // smallest legal capacity
      '{ROW_CAP, REQ_PUSH, 8'd1,  1'b0, 1'b0, ST_OK,      8'h00},
      '{ROW_REQ, REQ_PUSH, 8'h7E, 1'b0, 1'b1, ST_OK,      8'h00},
      '{ROW_REQ, REQ_LINE, 8'h00, 1'b0, 1'b1, ST_NO_LINE, 8'h00},
      '{ROW_REQ, REQ_POP,  8'h00, 1'b0, 1'b1, ST_OK,      8'h7E},
      // oversized capacity clamps to the full depth
      '{ROW_CAP, REQ_PUSH, 8'd127, 1'b0, 1'b0, ST_OK,     8'h00},
      '{ROW_REQ, REQ_PUSH, 8'h80, 1'b1, 1'b0, ST_OK,      8'h00},
      '{ROW_REQ, REQ_PEEK, 8'h00, 1'b0, 1'b1, ST_OK,      8'h80},
      '{ROW_REQ, REQ_LINE, 8'h00, 1'b0, 1'b0, ST_OK,      8'h00}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CAP) begin
        write_capacity(plan[i].data[CFG_W-1:0]);
      end else begin
        send_request(plan[i].req, plan[i].data, plan[i].eos, plan[i].typed,
                     plan[i].t_status, plan[i].t_data);
      end
    end

    // random phases
    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(phase_cap[ph]);
      gap_pct   = phase_gap[ph];
      stall_pct = phase_stall[ph];

      // a full-depth line: fill up, overflow once, read it all back
      if (ph == 0) begin
        for (int i = 0; i < DEPTH_DEF - 2; i++)
          send_request(REQ_PUSH, text_byte(), 1'b0, 1'b0, ST_OK, 8'h00);
        send_request(REQ_PUSH, text_byte(), 1'b1, 1'b0, ST_OK, 8'h00);
        send_request(REQ_PUSH, 8'hC3, 1'b0, 1'b1, ST_FULL, 8'h00);
        send_request(REQ_LINE, 8'h00, 1'b0, 1'b0, ST_OK, 8'h00);
      end

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // sender holds off until everything outstanding has come back
        if (ph == 1 && !paused && sent >= PHASE_ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 5) begin
          top = mirror_capacity();
          if ($urandom_range(0, 7) != 0 && top > 6) top = 6;
          len = $urandom_range(1, top);
          send_string(len);
          if ($urandom_range(0, 3) != 0)
            send_request(REQ_LINE, text_byte(), 1'b0, 1'b0, ST_OK, 8'h00);
          else
            send_request(REQ_POP, text_byte(), 1'b1, 1'b0, ST_OK, 8'h00);
          sent += len + 1;
        end else begin
          d = ($urandom_range(0, 3) == 0) ? NEWLINE : 8'($urandom_range(0, 255));
          send_request(req_t'($urandom_range(0, 3)), d, 1'($urandom_range(0, 1)),
                       1'b0, ST_OK, 8'h00);
          sent++;
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("covered %0d requests and %0d result beats at capacities 0, 1, 3, 17, 64",
             requests_sent, beats_checked);
    $display("and above depth, with sender gaps and receiver stalls in four mixes");
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("tb_line_aware_byte_fifo_unit: clean");
    end else begin
      $display("tb_line_aware_byte_fifo_unit: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_line_aware_byte_fifo_unit: errors");
    $finish;
  end

endmodule
